// ===== hw/rtl/lpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and constants of the permutation engine
// Opcodes, result status codes, the command word passed from the front end to
// the back end, and the back-end sequencer states.
// ----------------------------------------------------------------------------
package lpe_pkg;

	// default string capacity in characters
	localparam int LPE_MAX_LEN = 8;

	// depth of the command queue between front and back end
	localparam int LPE_QDEPTH = 2;

	// input opcodes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_START  = 2'd2,
		OP_NEXT   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_DONE  = 2'd2
	} stat_t;

	// command word held in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] byte_value;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_SORT,
		B_PIV,
		B_QSCAN,
		B_SWAP,
		B_EMIT,
		B_STAT
	} bstate_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lpe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_front: input stage
// Registers each accepted word, decodes its opcode into a command word and
// hands it to the command queue.
// ----------------------------------------------------------------------------
module lpe_front
	import lpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] byte_value,
	output logic            push_valid,
	input  wire logic       push_ready,
	output cmd_t            push_cmd
);

	logic fvld_q;
	cmd_t fcmd_q;
	logic in_fire;

	// stage is free when empty or when its word moves on this cycle
	assign in_ready   = !fvld_q || push_ready;
	assign in_fire    = in_valid && in_ready;
	assign push_valid = fvld_q;
	assign push_cmd   = fcmd_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q <= 1'b0;
		end else if (in_fire) begin
			fvld_q <= 1'b1;
		end else if (push_ready) begin
			fvld_q <= 1'b0;
		end
	end

	// decode and hold the word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fcmd_q.op         <= op_t'(opcode);
			fcmd_q.byte_value <= byte_value;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_queue: command queue
// Small FIFO of command words that lets the front end keep accepting while
// the back end works on a long command.
// ----------------------------------------------------------------------------
module lpe_queue
	import lpe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  cmd_t      push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int PW = (LPE_QDEPTH > 1) ? $clog2(LPE_QDEPTH) : 1;
	localparam int CW = $clog2(LPE_QDEPTH + 1);

	cmd_t          mem_q [LPE_QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(LPE_QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(LPE_QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(LPE_QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lpe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_back: execution unit
// Holds the string in a row of byte cells, sorts with odd-even transposition
// passes, finds the pivot and swap partner by scanning, and drives the
// registered result port.
// ----------------------------------------------------------------------------
module lpe_back
	import lpe_pkg::*;
#(
	parameter int MAX_LEN = LPE_MAX_LEN
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  cmd_t            cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      character,
	output logic            last_of_run,
	output logic [1:0]      status,
	output logic            overflowed
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int IW = $clog2(MAX_LEN);

	// string cells and their next values
	logic [7:0]    cs_q [MAX_LEN];
	logic [7:0]    cs_d [MAX_LEN];

	bstate_t       state_q, state_d;
	logic [LW-1:0] len_q, len_d;
	logic          ovf_q, ovf_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] p_q, p_d;
	logic [LW-1:0] lo_q, lo_d;
	logic [LW-1:0] pass_q, pass_d;
	logic [7:0]    pv_q, pv_d;
	logic [7:0]    qv_q, qv_d;
	stat_t         stat_q, stat_d;

	logic          ovld_q;
	logic [7:0]    ochar_q;
	logic          olast_q;
	stat_t         ostat_q;
	logic          oovf_q;

	logic          slot_free;
	logic          sort_en;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [7:0]    wr_data;
	logic          ld;
	logic [7:0]    ld_char;
	logic          ld_last;
	stat_t         ld_stat;
	logic [7:0]    rd_char;
	logic [MAX_LEN-1:0] asc;

	assign slot_free   = !ovld_q || out_ready;
	assign rd_char     = cs_q[idx_q];
	assign out_valid   = ovld_q;
	assign character   = ochar_q;
	assign last_of_run = olast_q;
	assign status      = ostat_q;
	assign overflowed  = oovf_q;

	// ascending flag of each neighbor pair
	always_comb begin
		asc = '0;
		for (int k = 0; k < MAX_LEN - 1; k++) begin
			asc[k] = (cs_q[k] < cs_q[k + 1]);
		end
	end

	// cell update: one transposition phase, or a single write
	always_comb begin
		for (int k = 0; k < MAX_LEN; k++) begin
			cs_d[k] = cs_q[k];
		end
		if (sort_en) begin
			for (int k = 0; k < MAX_LEN - 1; k++) begin
				if ((LW'(k % 2) == LW'(pass_q[0])) && (LW'(k) >= lo_q) &&
				    (LW'(k + 1) < len_q) && (cs_q[k] > cs_q[k + 1])) begin
					cs_d[k]     = cs_q[k + 1];
					cs_d[k + 1] = cs_q[k];
				end
			end
		end
		if (wr_en) begin
			cs_d[wr_idx] = wr_data;
		end
	end

	// sequencer: next state and controls
	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		ovf_d     = ovf_q;
		idx_d     = idx_q;
		p_d       = p_q;
		lo_d      = lo_q;
		pass_d    = pass_q;
		pv_d      = pv_q;
		qv_d      = qv_q;
		stat_d    = stat_q;
		cmd_ready = 1'b0;
		sort_en   = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = idx_q;
		wr_data   = pv_q;
		ld        = 1'b0;
		ld_char   = '0;
		ld_last   = 1'b0;
		ld_stat   = ST_OK;
		case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd.op)
						OP_CLEAR: begin
							len_d = '0;
							ovf_d = 1'b0;
						end
						OP_APPEND: begin
							if (len_q < LW'(MAX_LEN)) begin
								wr_en   = 1'b1;
								wr_idx  = len_q[IW-1:0];
								wr_data = cmd.byte_value;
								len_d   = len_q + LW'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_START: begin
							if (len_q == '0) begin
								stat_d  = ST_EMPTY;
								state_d = B_STAT;
							end else begin
								lo_d    = '0;
								pass_d  = '0;
								state_d = B_SORT;
							end
						end
						OP_NEXT: begin
							if (len_q == '0) begin
								stat_d  = ST_EMPTY;
								state_d = B_STAT;
							end else if (len_q == LW'(1)) begin
								stat_d  = ST_DONE;
								state_d = B_STAT;
							end else begin
								idx_d   = IW'(len_q - LW'(2));
								state_d = B_PIV;
							end
						end
						default: ;
					endcase
				end
			end
			B_SORT: begin
				sort_en = 1'b1;
				if (pass_q == len_q - LW'(1)) begin
					idx_d   = '0;
					state_d = B_EMIT;
				end else begin
					pass_d = pass_q + LW'(1);
				end
			end
			// scan down for the rightmost ascending pair
			B_PIV: begin
				if (asc[idx_q]) begin
					p_d     = idx_q;
					pv_d    = rd_char;
					idx_d   = IW'(len_q - LW'(1));
					state_d = B_QSCAN;
				end else if (idx_q == '0) begin
					stat_d  = ST_DONE;
					state_d = B_STAT;
				end else begin
					idx_d = idx_q - IW'(1);
				end
			end
			// scan down for the rightmost byte above the pivot
			B_QSCAN: begin
				if (rd_char > pv_q) begin
					wr_en   = 1'b1;
					wr_idx  = idx_q;
					wr_data = pv_q;
					qv_d    = rd_char;
					state_d = B_SWAP;
				end else begin
					idx_d = idx_q - IW'(1);
				end
			end
			// finish the swap; the descending suffix is then sorted ascending
			B_SWAP: begin
				wr_en   = 1'b1;
				wr_idx  = p_q;
				wr_data = qv_q;
				lo_d    = LW'(p_q) + LW'(1);
				pass_d  = '0;
				state_d = B_SORT;
			end
			B_EMIT: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_char = rd_char;
					ld_last = (LW'(idx_q) == len_q - LW'(1));
					if (ld_last) begin
						state_d = B_IDLE;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end
			end
			B_STAT: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_last = 1'b1;
					ld_stat = stat_q;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			p_q     <= '0;
			lo_q    <= '0;
			pass_q  <= '0;
			stat_q  <= ST_OK;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			ovf_q   <= ovf_d;
			idx_q   <= idx_d;
			p_q     <= p_d;
			lo_q    <= lo_d;
			pass_q  <= pass_d;
			stat_q  <= stat_d;
			ovld_q  <= ld || (ovld_q && !out_ready);
		end
	end

	// cells and operand holding registers
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LEN; k++) begin
			cs_q[k] <= cs_d[k];
		end
		pv_q <= pv_d;
		qv_q <= qv_d;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (ld) begin
			ochar_q <= ld_char;
			olast_q <= ld_last;
			ostat_q <= ld_stat;
			oovf_q  <= ovf_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lexicographic_permutation_engine.sv =====
`default_nettype none
// Input words pass a register and a 2-deep queue, results an output register.
// Clear and append: no result; the back end retires one each cycle. Start: accept,
// n transposition passes, then n result words, one per cycle unless out_ready stalls.
// Next: pivot and partner scans over up to n-1 bytes each, a swap, n passes over the
// suffix, then n result words (n = string length). Empty or no next: one status word.
// Reset clears length, overflow mark and all handshakes; cell contents are undefined.
// ----------------------------------------------------------------------------
// lexicographic_permutation_engine: top level
// Front end registers and decodes input words, a command queue buffers them,
// and the back end sorts, permutes and emits the string.
// ----------------------------------------------------------------------------
module lexicographic_permutation_engine
	import lpe_pkg::*;
#(
	parameter int MAX_LEN = LPE_MAX_LEN
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] byte_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      character,
	output logic            last_of_run,
	output logic [1:0]      status,
	output logic            overflowed
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// input stage
	lpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.byte_value (byte_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// command queue
	lpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// execution unit
	lpe_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last_of_run (last_of_run),
		.status      (status),
		.overflowed  (overflowed)
	);

endmodule
`default_nettype wire

// ===== test/tb_lexicographic_permutation_engine.sv =====
// ----------------------------------------------------------------------------
// tb_lexicographic_permutation_engine: self-checking bench for the engine
// Drives opcode words through the input handshake and predicts the result
// words from a shadow copy of the string. Each result word is checked field
// by field against the oldest prediction. Directed words come first, then
// random clear/append/start/next sequences under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_lexicographic_permutation_engine;
	import lpe_pkg::*;

	localparam int MAX_LEN     = LPE_MAX_LEN;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 100;

	// one predicted result word
	typedef struct {
		logic [7:0] character;
		logic       last_of_run;
		stat_t      status;
		logic       overflowed;
	} perm_word_t;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [1:0] opcode     = 2'd0;
	logic [7:0] byte_value = 8'd0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] character;
	logic       last_of_run;
	logic [1:0] status;
	logic       overflowed;

	// shadow copy of the engine's string
	logic [7:0]  shadow_chars [MAX_LEN];
	int unsigned shadow_len = 0;
	logic        shadow_ovf = 1'b0;

	perm_word_t  pending_perm_words [$];
	cmd_t        word_backlog [$];
	cmd_t        in_flight;
	int unsigned sent_count     = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned stall_pct      = 0;

	lexicographic_permutation_engine #(
		.MAX_LEN(MAX_LEN)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last_of_run(last_of_run),
		.status     (status),
		.overflowed (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void swap_chars(int unsigned a, int unsigned b);
		logic [7:0] t;
		t = shadow_chars[a];
		shadow_chars[a] = shadow_chars[b];
		shadow_chars[b] = t;
	endfunction

	function automatic void push_status_word(stat_t st);
		perm_word_t w;
		w.character   = 8'd0;
		w.last_of_run = 1'b1;
		w.status      = st;
		w.overflowed  = shadow_ovf;
		pending_perm_words.push_back(w);
	endfunction

	function automatic void push_char_run();
		perm_word_t w;
		for (int unsigned k = 0; k < shadow_len; k++) begin
			w.character   = shadow_chars[k];
			w.last_of_run = (k + 1 == shadow_len);
			w.status      = ST_OK;
			w.overflowed  = shadow_ovf;
			pending_perm_words.push_back(w);
		end
	endfunction

	function automatic void predict_perm_words(op_t op, logic [7:0] b);
		int unsigned p, q, lo, hi;
		bit advanced;
		case (op)
		OP_CLEAR: begin
			shadow_len = 0;
			shadow_ovf = 1'b0;
		end
		OP_APPEND: begin
			if (shadow_len < MAX_LEN) begin
				shadow_chars[shadow_len] = b;
				shadow_len++;
			end else begin
				shadow_ovf = 1'b1;
			end
		end
		OP_START: begin
			if (shadow_len == 0) begin
				push_status_word(ST_EMPTY);
			end else begin
				// exchange sort, ascending
				for (int unsigned i = 0; i + 1 < shadow_len; i++)
					for (int unsigned j = i + 1; j < shadow_len; j++)
						if (shadow_chars[i] > shadow_chars[j])
							swap_chars(i, j);
				push_char_run();
			end
		end
		default: begin
			advanced = 1'b0;
			if (shadow_len >= 2) begin
				// rightmost pivot below its right neighbor
				p = shadow_len - 1;
				while (p > 0 && shadow_chars[p - 1] >= shadow_chars[p])
					p--;
				if (p > 0) begin
					p--;
					q = shadow_len - 1;
					while (shadow_chars[q] <= shadow_chars[p])
						q--;
					swap_chars(p, q);
					lo = p + 1;
					hi = shadow_len - 1;
					while (lo < hi) begin
						swap_chars(lo, hi);
						lo++;
						hi--;
					end
					advanced = 1'b1;
				end
			end
			if (shadow_len == 0)
				push_status_word(ST_EMPTY);
			else if (!advanced)
				push_status_word(ST_DONE);
			else
				push_char_run();
		end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// input driver: keeps valid up across back-to-back words
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_perm_words(in_flight.op, in_flight.byte_value);
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_flight = word_backlog.pop_front();
					opcode     <= in_flight.op;
					byte_value <= in_flight.byte_value;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", what);
	endtask

	always @(posedge clk) begin : check_results
		perm_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_perm_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word char %02h last %0d status %0d ovf %0d",
					character, last_of_run, status, overflowed));
			end else begin
				want = pending_perm_words.pop_front();
				if (character !== want.character || last_of_run !== want.last_of_run ||
						status !== want.status || overflowed !== want.overflowed)
					report_mismatch($sformatf(
						"exp char %02h last %0d status %0d ovf %0d, got %02h %0d %0d %0d",
						want.character, want.last_of_run, want.status, want.overflowed,
						character, last_of_run, status, overflowed));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_lexicographic_permutation_engine failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic send_word(op_t op, logic [7:0] b);
		cmd_t w;
		w.op         = op;
		w.byte_value = b;
		while (word_backlog.size() >= 2)
			@(posedge clk);
		word_backlog.push_back(w);
		sent_count++;
	endtask

	task automatic test_empty_string();
		send_word(OP_START, 8'hFF);
		send_word(OP_NEXT, 8'h00);
		send_word(OP_CLEAR, 8'hA5);
		send_word(OP_START, 8'h5A);
	endtask

	// one character: next has nowhere to go
	task automatic test_single_character();
		send_word(OP_APPEND, 8'hFF);
		send_word(OP_NEXT, 8'h00);
		send_word(OP_START, 8'h00);
		send_word(OP_CLEAR, 8'h00);
	endtask

	// full string of extreme bytes, then one dropped byte
	task automatic test_extremes_and_overflow();
		logic [7:0] vals [MAX_LEN] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
		foreach (vals[i])
			send_word(OP_APPEND, vals[i]);
		send_word(OP_APPEND, 8'h33);
		send_word(OP_START, 8'h00);
		send_word(OP_NEXT, 8'hFF);
		send_word(OP_NEXT, 8'h00);
		send_word(OP_CLEAR, 8'h00);
	endtask

	// equal bytes have a single ordering
	task automatic test_repeated_bytes();
		send_word(OP_APPEND, 8'h05);
		send_word(OP_APPEND, 8'h05);
		send_word(OP_START, 8'h00);
		send_word(OP_NEXT, 8'h00);
		send_word(OP_CLEAR, 8'h00);
	endtask

	task automatic test_random_permutations(int unsigned idle, int unsigned stall);
		int unsigned first, n, nexts, r;
		logic [7:0] base;
		bit narrow;
		send_idle_pct = idle;
		stall_pct     = stall;
		first = sent_count;
		while (sent_count - first < PHASE_WORDS) begin
			if ($urandom_range(99) < 20) begin
				// noise: arbitrary words
				repeat ($urandom_range(1, 3))
					send_word(op_t'($urandom_range(3)), 8'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				if (r < 60)
					n = $urandom_range(1, 3);
				else if (r < 90)
					n = $urandom_range(4, MAX_LEN);
				else
					n = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
				narrow = $urandom_range(1);
				base   = 8'($urandom_range(253));
				if ($urandom_range(9) != 0)
					send_word(OP_CLEAR, 8'($urandom_range(255)));
				repeat (n) begin
					if (narrow)
						send_word(OP_APPEND, base + 8'($urandom_range(2)));
					else
						send_word(OP_APPEND, 8'($urandom_range(255)));
				end
				if ($urandom_range(9) != 0)
					send_word(OP_START, 8'($urandom_range(255)));
				nexts = (n <= 3) ? $urandom_range(1, 7) : $urandom_range(0, 5);
				repeat (nexts)
					send_word(OP_NEXT, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		foreach (shadow_chars[i])
			shadow_chars[i] = 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_string();
		test_single_character();
		test_extremes_and_overflow();
		test_repeated_bytes();
		test_random_permutations(0, 0);
		test_random_permutations(85, 0);
		test_random_permutations(0, 85);
		test_random_permutations(38, 38);

		// drain, then allow the back end to settle
		while (accepted_count != sent_count || pending_perm_words.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (mismatch_count == 0 && pending_perm_words.size() == 0) begin
			$display("tb_lexicographic_permutation_engine passed");
		end else begin
			$display("tb_lexicographic_permutation_engine failed");
		end
		$finish;
	end

endmodule
